// File: rtl/zia_pkg.sv
// Shared constants and types for the zoned intrusion alarm keypad.
`timescale 1ns / 1ps

package zia_pkg;

	localparam int ZoneCount   = 4;
	localparam int SensorCount = 8;
	localparam int CodeLength  = 4;

	localparam int ZoneW   = 2;
	localparam int CharW   = 8;
	localparam int TriesW  = 4;
	localparam int PosW    = $clog2(CodeLength);
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = CharW * CodeLength;
	localparam int MapW    = ZoneW * SensorCount;
	localparam int AdjW    = 16;

	localparam logic [CfgDataW-1:0] AccessCodeReset = '0;
	localparam logic                ZoneCheckReset  = 1'b1;
	localparam logic [MapW-1:0]     ZoneMapReset    = MapW'(38208);
	localparam logic [AdjW-1:0]     ZoneAdjReset    = AdjW'(594);
	localparam logic [TriesW-1:0]   MaxTriesReset   = TriesW'(3);
	localparam logic [TriesW-1:0]   TriesReset      = TriesW'(3);

	typedef enum logic [1:0] {
		RES_NONE    = 2'd0,
		RES_OK      = 2'd1,
		RES_WRONG   = 2'd2,
		RES_LOCKOUT = 2'd3
	} code_res_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ACCESS_CODE = 3'd0,
		CFG_ZONE_CHECK  = 3'd1,
		CFG_ZONE_MAP    = 3'd2,
		CFG_ZONE_ADJ    = 3'd3,
		CFG_MAX_TRIES   = 3'd4
	} cfg_idx_t;

endpackage

// File: rtl/zoned_intrusion_alarm_keypad.sv
// Top level of the zoned intrusion alarm keypad: motion zoning, code entry and siren control.
`timescale 1ns / 1ps

// Usage
// Each input beat is one panel cycle: a motion sensor bitmap plus an optional keypad
// character (key_present; a character of zero is ignored). Each input beat gives exactly
// one output beat with the siren, armed and tries state after that panel cycle, and the
// outcome of any code check finished by it.
// Both data channels use valid/stall: a beat moves on a rising edge with valid high and
// stall low. Configuration writes use cfg_valid/cfg_ready, cfg_ready is always high, and
// they should only be issued while no beat is in flight.
// A beat is captured in an input register; the panel state is then updated and the
// result is written into the output register. Throughput is one beat per cycle while
// the receiver does not stall, set by the single pass of zone and code logic between
// those two registers.
// When the receiver stalls, the output register holds its beat. An empty input register
// can still take one beat; once both registers are full, in_stall is high, driven
// combinationally from out_stall. Reset (arst_n low) empties both registers, arms the
// panel, silences the siren, clears the code entry, sets the tries to three and loads
// the register defaults.
module zoned_intrusion_alarm_keypad (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     motion_sensors,
	input  logic                           key_present,
	input  logic [7:0]                     key_char,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           alarm_on,
	output logic                           armed,
	output logic [3:0]                     tries_left,
	output logic [1:0]                     code_result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [zia_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [zia_pkg::CfgDataW-1:0]   cfg_data
);
	import zia_pkg::*;

	// Configuration registers.
	logic [CfgDataW-1:0] access_code_q;
	logic                zone_check_q;
	logic [MapW-1:0]     zone_map_q;
	logic [AdjW-1:0]     zone_adj_q;
	logic [TriesW-1:0]   max_tries_q;

	// Panel state.
	logic                armed_q;
	logic                siren_q;
	logic [ZoneW-1:0]    cur_zone_q;
	logic [ZoneW-1:0]    prev_zone_q;
	logic [CharW-1:0]    entry_buffer_q [CodeLength-1];
	logic [PosW-1:0]     entry_pos_q;
	logic [TriesW-1:0]   tries_q;

	// Input register.
	logic                valid_s1;
	logic [7:0]          motion_s1;
	logic                key_present_s1;
	logic [CharW-1:0]    key_char_s1;

	// Output register.
	logic                valid_s2;
	logic                alarm_s2;
	logic                armed_s2;
	logic [TriesW-1:0]   tries_s2;
	code_res_t           result_s2;

	// Handshake control.
	logic                advance;
	logic                fire;
	logic                take_in;

	// Single-pass datapath.
	logic [SensorCount-1:0] active;
	logic [SensorCount-1:0] in_zone [ZoneCount];
	logic [ZoneCount-1:0]   zone_hit;
	logic [ZoneCount-1:0]   zone_multi;
	logic [ZoneW-1:0]       cur_zone_d;
	logic [ZoneW-1:0]       prev_zone_d;
	logic                   motion_go;
	logic                   motion_siren;
	logic                   key_go;
	logic                   entry_full;
	logic                   code_match;
	logic                   siren_d;
	logic                   armed_d;
	logic [TriesW-1:0]      tries_d;
	code_res_t              result_d;

	// The output register may load when it is empty or its beat is being taken. The
	// input register moves on in that case, and can then also take a fresh beat.
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Only the sensors that exist take part; a sensor mapped to a zone at or above the
	// zone count still counts as motion but never moves the zones.
	assign active = motion_s1[SensorCount-1:0];

	always_comb begin
		for (int z = 0; z < ZoneCount; z++) begin
			for (int k = 0; k < SensorCount; k++) begin
				in_zone[z][k] = active[k] && (zone_map_q[ZoneW*k +: ZoneW] == ZoneW'(z));
			end
			zone_hit[z]   = |in_zone[z];
			// Two or more sensors in one zone leave both zone registers on that zone.
			zone_multi[z] = |(in_zone[z] & (in_zone[z] - SensorCount'(1)));
		end
	end

	// The walk visits zones in ascending order, so only the last two visited sensors
	// matter: one step per zone over the two-bit zone numbers.
	always_comb begin
		cur_zone_d  = cur_zone_q;
		prev_zone_d = prev_zone_q;
		for (int z = 0; z < ZoneCount; z++) begin
			if (zone_multi[z]) begin
				prev_zone_d = ZoneW'(z);
				cur_zone_d  = ZoneW'(z);
			end else if (zone_hit[z]) begin
				prev_zone_d = cur_zone_d;
				cur_zone_d  = ZoneW'(z);
			end
		end
	end

	// With the zone check on, zones are linked in either direction of the adjacency map; equal
	// or linked zones mean a plausible walk, so the siren stays silent; else motion sounds it.
	always_comb begin
		logic linked;
		linked = zone_adj_q[{cur_zone_d, prev_zone_d}] || zone_adj_q[{prev_zone_d, cur_zone_d}];
		if (zone_check_q) begin
			motion_siren = !((cur_zone_d == prev_zone_d) || linked);
		end else begin
			motion_siren = 1'b1;
		end
	end

	assign motion_go  = armed_q && (|active);
	assign key_go     = key_present_s1 && (key_char_s1 != '0);
	assign entry_full = (entry_pos_q == PosW'(CodeLength - 1));

	// The last key of a code is compared as it arrives, the earlier ones from the buffer.
	always_comb begin
		code_match = (key_char_s1 == access_code_q[CharW*(CodeLength-1) +: CharW]);
		for (int i = 0; i < CodeLength - 1; i++) begin
			if (entry_buffer_q[i] != access_code_q[CharW*i +: CharW]) begin
				code_match = 1'b0;
			end
		end
	end

	// Motion is handled first; a finished code entry may then override the siren.
	always_comb begin
		siren_d  = motion_go ? motion_siren : siren_q;
		armed_d  = armed_q;
		tries_d  = tries_q;
		result_d = RES_NONE;
		if (key_go && entry_full) begin
			priority if (code_match) begin
				armed_d  = 1'b0;
				siren_d  = 1'b0;
				tries_d  = max_tries_q;
				result_d = RES_OK;
			end else if (tries_q <= TriesW'(1)) begin
				tries_d  = max_tries_q;
				siren_d  = 1'b1;
				result_d = RES_LOCKOUT;
			end else begin
				tries_d  = tries_q - TriesW'(1);
				result_d = RES_WRONG;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_code_q <= AccessCodeReset;
			zone_check_q  <= ZoneCheckReset;
			zone_map_q    <= ZoneMapReset;
			zone_adj_q    <= ZoneAdjReset;
			max_tries_q   <= MaxTriesReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ACCESS_CODE: access_code_q <= cfg_data;
				CFG_ZONE_CHECK:  zone_check_q  <= cfg_data[0];
				CFG_ZONE_MAP:    zone_map_q    <= cfg_data[MapW-1:0];
				CFG_ZONE_ADJ:    zone_adj_q    <= cfg_data[AdjW-1:0];
				CFG_MAX_TRIES:   max_tries_q   <= cfg_data[TriesW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Panel state, updated once for each beat as it passes into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b1;
			siren_q     <= 1'b0;
			cur_zone_q  <= '0;
			prev_zone_q <= '0;
			entry_pos_q <= '0;
			tries_q     <= TriesReset;
			for (int i = 0; i < CodeLength - 1; i++) begin
				entry_buffer_q[i] <= '0;
			end
		end else if (fire) begin
			armed_q <= armed_d;
			siren_q <= siren_d;
			tries_q <= tries_d;
			if (motion_go) begin
				cur_zone_q  <= cur_zone_d;
				prev_zone_q <= prev_zone_d;
			end
			if (key_go) begin
				if (entry_full) begin
					entry_pos_q <= '0;
					for (int i = 0; i < CodeLength - 1; i++) begin
						entry_buffer_q[i] <= '0;
					end
				end else begin
					entry_pos_q <= entry_pos_q + PosW'(1);
					for (int i = 0; i < CodeLength - 1; i++) begin
						if (entry_pos_q == PosW'(i)) begin
							entry_buffer_q[i] <= key_char_s1;
						end
					end
				end
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			motion_s1      <= motion_sensors;
			key_present_s1 <= key_present;
			key_char_s1    <= key_char;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			alarm_s2  <= siren_d;
			armed_s2  <= armed_d;
			tries_s2  <= tries_d;
			result_s2 <= result_d;
		end
	end

	assign out_valid   = valid_s2;
	assign alarm_on    = alarm_s2;
	assign armed       = armed_s2;
	assign tries_left  = tries_s2;
	assign code_result = result_s2;

	// A correct code always leaves the panel disarmed.
	a_ok_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (result_s2 == RES_OK) |-> !armed_s2)
		else $error("correct code reported while panel still armed");

	// The lockout always sounds the siren.
	a_lockout_siren: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (result_s2 == RES_LOCKOUT) |-> alarm_s2)
		else $error("lockout reported with the siren silent");

	// Nothing but reset re-arms the panel.
	a_no_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(armed_q))
		else $error("panel re-armed without reset");

	// The input side only stalls behind a full, stalled output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked output beat");

endmodule
